[hw/rtl/assert_macros.svh]
// Assertion macros shared by the optimizer update RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ADP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/adp_pkg.sv]
// Shared types and constants of the Adam parameter update block.
// No dependencies; used by every RTL module of the block.
package adp_pkg;

	localparam int FRAC = 24;
	localparam int DIV_W = 56;
	localparam int DVS_W = 29;
	localparam int ROOT_W = 28;
	localparam logic [24:0] ONE25 = 25'h1000000;
	localparam logic signed [63:0] QDIV = 64'sd16777216;

	typedef enum logic [1:0] {
		REG_STEP = 2'd0,
		REG_B1   = 2'd1,
		REG_B2   = 2'd2,
		REG_EPS  = 2'd3
	} adp_reg_t;

	typedef struct packed {
		logic [23:0] step;
		logic [23:0] b1;
		logic [23:0] b2;
		logic [23:0] eps;
	} adp_cfg_t;

	typedef struct packed {
		logic               upd;
		logic               held;
		logic [12:0]        batch;
		logic [11:0]        index;
		logic               grad_neg;
		logic [31:0]        grad_mag;
		logic signed [31:0] weight;
	} adp_beat_t;

	typedef struct packed {
		logic      valid;
		adp_beat_t beat;
	} adp_head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} adp_stat_t;

	typedef struct packed {
		logic               start;
		logic [DIV_W-1:0]   dividend;
		logic [DVS_W-1:0]   divisor;
		logic [5:0]         steps;
	} adp_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} adp_div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] radicand;
	} adp_sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} adp_sqrt_rsp_t;

endpackage

[hw/rtl/adp_div.sv]
// Shared bit-serial restoring divider, one quotient bit per cycle.
// Depends on adp_pkg for request and response types.
module adp_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  adp_pkg::adp_div_req_t req,
	output adp_pkg::adp_div_rsp_t rsp
);

	logic                           active_q;
	logic                           done_q;
	logic [5:0]                     cnt_q;
	logic [adp_pkg::DVS_W:0]        rem_q;
	logic [adp_pkg::DIV_W-1:0]      quo_q;
	logic [adp_pkg::DVS_W-1:0]      dvs_q;
	logic [adp_pkg::DVS_W+1:0]      shifted;
	logic [adp_pkg::DVS_W+2:0]      diff;
	logic                           ge;

	assign shifted = {rem_q, quo_q[adp_pkg::DIV_W-1]};
	assign diff = {1'b0, shifted} - {3'b000, dvs_q};
	assign ge = !diff[adp_pkg::DVS_W+2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (active_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (active_q) begin
			rem_q <= ge ? diff[adp_pkg::DVS_W:0] : shifted[adp_pkg::DVS_W:0];
			quo_q <= {quo_q[adp_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

[hw/rtl/adp_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on adp_pkg for request and response types.
module adp_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  adp_pkg::adp_sqrt_req_t req,
	output adp_pkg::adp_sqrt_rsp_t rsp
);

	logic                         active_q;
	logic                         done_q;
	logic [4:0]                   cnt_q;
	logic [adp_pkg::ROOT_W+1:0]   rem_q;
	logic [adp_pkg::ROOT_W-1:0]   root_q;
	logic [adp_pkg::DIV_W-1:0]    x_q;
	logic [adp_pkg::ROOT_W+3:0]   shifted;
	logic [adp_pkg::ROOT_W+3:0]   sub;
	logic [adp_pkg::ROOT_W+4:0]   diff;
	logic                         ge;

	assign shifted = {rem_q, x_q[adp_pkg::DIV_W-1 -: 2]};
	assign sub = {2'b00, root_q, 2'b01};
	assign diff = {1'b0, shifted} - {1'b0, sub};
	assign ge = !diff[adp_pkg::ROOT_W+4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q <= 5'(adp_pkg::ROOT_W);
			end else if (active_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			root_q <= '0;
			x_q <= req.radicand;
		end else if (active_q) begin
			rem_q <= ge ? diff[adp_pkg::ROOT_W+1:0] : shifted[adp_pkg::ROOT_W+1:0];
			root_q <= {root_q[adp_pkg::ROOT_W-2:0], ge};
			x_q <= {x_q[adp_pkg::DIV_W-3:0], 2'b00};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

[hw/rtl/adp_front.sv]
// Command front end: accepts beats, classifies them and holds a two-entry queue.
// Depends on adp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module adp_front #(
	parameter int PARAM_DEPTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [12:0]         batch_count,
	input  logic [11:0]         param_index,
	input  logic signed [31:0]  grad_sum,
	input  logic signed [31:0]  old_weight,
	input  adp_pkg::adp_stat_t  stat,
	output adp_pkg::adp_head_t  head
);

	adp_pkg::adp_beat_t beat_d;
	adp_pkg::adp_beat_t ent_q [2];
	logic               wr_q;
	logic               rd_q;
	logic [1:0]         count_q;
	logic               accept;

	always_comb begin
		beat_d.upd = mode;
		beat_d.held = {20'b0, param_index} < 32'(PARAM_DEPTH);
		beat_d.batch = (batch_count == 13'd0) ? 13'd1 : batch_count;
		beat_d.index = param_index;
		beat_d.grad_neg = grad_sum[31];
		beat_d.grad_mag = grad_sum[31] ? (~grad_sum + 32'd1) : grad_sum;
		beat_d.weight = old_weight;
	end

	assign busy = (count_q == 2'd2) || stat.clearing;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept)
				wr_q <= ~wr_q;
			if (stat.pop)
				rd_q <= ~rd_q;
			unique case ({accept, stat.pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			ent_q[wr_q] <= beat_d;
	end

	assign head.valid = count_q != 2'd0;
	assign head.beat = ent_q[rd_q];

	`ADP_ASSERT_NOW(a_pop_nonempty, stat.pop, count_q != 2'd0, "pop from empty queue")
	`ADP_ASSERT_NEXT(a_fill, accept && !stat.pop, count_q == 2'($past(count_q) + 2'd1),
		"queue fill count wrong")
	`ADP_ASSERT_NEXT(a_drain, stat.pop && !accept, count_q == 2'($past(count_q) - 2'd1),
		"queue drain count wrong")

endmodule

[hw/rtl/adp_back.sv]
// Back end sequencer: beta powers, bias-corrected rate, moment stores and weight update.
// Depends on adp_pkg, the shared divider and root units, and assert_macros.svh.
`include "assert_macros.svh"

module adp_back #(
	parameter int PARAM_DEPTH = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  adp_pkg::adp_cfg_t      cfg,
	input  adp_pkg::adp_head_t     head,
	output adp_pkg::adp_stat_t     stat,
	output adp_pkg::adp_div_req_t  div_req,
	input  adp_pkg::adp_div_rsp_t  div_rsp,
	output adp_pkg::adp_sqrt_req_t sq_req,
	input  adp_pkg::adp_sqrt_rsp_t sq_rsp,
	output logic                   done,
	output logic [11:0]            out_index,
	output logic signed [31:0]     new_weight,
	output logic                   saturated
);

	localparam int AW = $clog2(PARAM_DEPTH);

	typedef enum logic [17:0] {
		S_IDLE    = 18'h00001,
		S_POW     = 18'h00002,
		S_BSQ_GO  = 18'h00004,
		S_BSQ     = 18'h00008,
		S_BMUL    = 18'h00010,
		S_BDIV_GO = 18'h00020,
		S_BDIV    = 18'h00040,
		S_GDIV    = 18'h00080,
		S_UMUL1   = 18'h00100,
		S_UMUL2   = 18'h00200,
		S_UMUL3   = 18'h00400,
		S_UMUL4   = 18'h00800,
		S_USQ_GO  = 18'h01000,
		S_USQ     = 18'h02000,
		S_UDIV_GO = 18'h04000,
		S_UDIV    = 18'h08000,
		S_UMULR   = 18'h10000,
		S_UOUT    = 18'h20000
	} adp_state_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} adp_clamp_t;

	function automatic adp_clamp_t clamp32(input logic signed [65:0] x);
		adp_clamp_t r;
		if (x > 66'sd2147483647) begin
			r.val = 32'sh7fffffff;
			r.sat = 1'b1;
		end else if (x < -66'sd2147483648) begin
			r.val = 32'sh80000000;
			r.sat = 1'b1;
		end else begin
			r.val = x[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	adp_state_t         state_q;
	logic               clr_q;
	logic [AW-1:0]      clr_addr_q;
	logic [24:0]        b1p_q;
	logic [24:0]        b2p_q;
	logic [31:0]        rate_q;
	logic [12:0]        batch_q;
	logic               done_q;

	adp_pkg::adp_beat_t cur_q;
	logic [31:0]        m_mem [PARAM_DEPTH];
	logic [31:0]        v_mem [PARAM_DEPTH];
	logic [31:0]        rd_m_q;
	logic [31:0]        rd_v_q;
	logic [51:0]        rprod_q;
	logic [31:0]        gmag_q;
	logic signed [56:0] p1_q;
	logic signed [58:0] p2_q;
	logic [63:0]        p3_q;
	logic [55:0]        p4_q;
	logic signed [31:0] m_new_q;
	logic [39:0]        g2_q;
	logic [31:0]        v4_q;
	logic [44:0]        plo_q;
	logic [44:0]        phi_q;
	logic [31:0]        v_new_q;
	logic [28:0]        den_q;
	logic signed [31:0] q_q;
	logic signed [64:0] rp_q;
	logic               sat_q;
	logic [11:0]        out_index_q;
	logic signed [31:0] new_weight_q;
	logic               saturated_q;

	logic               pop;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      cur_addr;
	logic [31:0]        rd_idx32;
	logic [31:0]        cur_idx32;
	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic               upd_we;
	logic [48:0]        b1p_prod;
	logic [48:0]        b2p_prod;
	logic [24:0]        omb1;
	logic [24:0]        omb2;
	logic [24:0]        omb1c;
	logic [24:0]        omb2c;
	logic signed [31:0] m_in;
	logic [31:0]        v_in;
	logic signed [32:0] g_s;
	logic signed [65:0] msum;
	adp_clamp_t         mclamp;
	logic [65:0]        vtot;
	logic [42:0]        vsum;
	logic [31:0]        mmag;
	logic signed [65:0] qs;
	adp_clamp_t         qclamp;
	logic signed [65:0] nw;
	adp_clamp_t         wclamp;

	assign pop = (state_q == S_IDLE) && head.valid && !clr_q;
	assign stat.pop = pop;
	assign stat.clearing = clr_q;

	assign rd_idx32 = 32'(head.beat.index);
	assign rd_addr = rd_idx32[AW-1:0];
	assign cur_idx32 = 32'(cur_q.index);
	assign cur_addr = cur_idx32[AW-1:0];
	assign upd_we = (state_q == S_USQ_GO) && cur_q.held;
	assign mem_we = clr_q || upd_we;
	assign mem_addr = clr_q ? clr_addr_q : cur_addr;

	assign b1p_prod = b1p_q * cfg.b1;
	assign b2p_prod = b2p_q * cfg.b2;
	assign omb1 = adp_pkg::ONE25 - b1p_q;
	assign omb2 = adp_pkg::ONE25 - b2p_q;
	assign omb1c = adp_pkg::ONE25 - {1'b0, cfg.b1};
	assign omb2c = adp_pkg::ONE25 - {1'b0, cfg.b2};

	assign m_in = cur_q.held ? $signed(rd_m_q) : 32'sd0;
	assign v_in = cur_q.held ? rd_v_q : 32'd0;
	assign g_s = cur_q.grad_neg ? -$signed({1'b0, gmag_q}) : $signed({1'b0, gmag_q});
	assign msum = (66'(p1_q) / adp_pkg::QDIV) + (66'(p2_q) / adp_pkg::QDIV);
	assign mclamp = clamp32(msum);
	assign vtot = {1'b0, phi_q, 20'b0} + {21'b0, plo_q};
	assign vsum = {11'b0, v4_q} + {1'b0, vtot[65:24]};
	assign mmag = m_new_q[31] ? (~m_new_q + 32'd1) : m_new_q;
	assign qs = m_new_q[31] ? -$signed({10'b0, div_rsp.quotient})
		: $signed({10'b0, div_rsp.quotient});
	assign qclamp = clamp32(qs);
	assign nw = 66'($signed(cur_q.weight)) - (66'(rp_q) / adp_pkg::QDIV);
	assign wclamp = clamp32(nw);

	// Divider and root requests are issued from the sequencer states.
	always_comb begin
		div_req.start = 1'b0;
		div_req.dividend = '0;
		div_req.divisor = '0;
		div_req.steps = '0;
		sq_req.start = 1'b0;
		sq_req.radicand = '0;
		priority if (pop && head.beat.upd) begin
			div_req.start = 1'b1;
			div_req.dividend = {head.beat.grad_mag, 24'b0};
			div_req.divisor = {16'b0, batch_q};
			div_req.steps = 6'd32;
		end else if (state_q == S_BDIV_GO && omb1 != 25'd0) begin
			div_req.start = 1'b1;
			div_req.dividend = {rprod_q, 4'b0};
			div_req.divisor = {4'b0, omb1};
			div_req.steps = 6'd52;
		end else if (state_q == S_UDIV_GO && den_q != 29'd0) begin
			div_req.start = 1'b1;
			div_req.dividend = {mmag, 24'b0};
			div_req.divisor = den_q;
			div_req.steps = 6'd56;
		end else if (state_q == S_BSQ_GO) begin
			sq_req.start = 1'b1;
			sq_req.radicand = {7'b0, omb2, 24'b0};
		end else if (state_q == S_USQ_GO) begin
			sq_req.start = 1'b1;
			sq_req.radicand = {v_new_q, 24'b0};
		end else begin
			div_req.start = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clr_q <= 1'b1;
			clr_addr_q <= '0;
			b1p_q <= adp_pkg::ONE25;
			b2p_q <= adp_pkg::ONE25;
			rate_q <= '0;
			batch_q <= 13'd1;
			done_q <= 1'b0;
		end else begin
			done_q <= state_q == S_UOUT;
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(PARAM_DEPTH - 1))
					clr_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop)
						state_q <= head.beat.upd ? S_GDIV : S_POW;
				end
				S_POW: begin
					b1p_q <= b1p_prod[48:24];
					b2p_q <= b2p_prod[48:24];
					batch_q <= cur_q.batch;
					state_q <= S_BSQ_GO;
				end
				S_BSQ_GO: state_q <= S_BSQ;
				S_BSQ: begin
					if (sq_rsp.done)
						state_q <= S_BMUL;
				end
				S_BMUL: state_q <= S_BDIV_GO;
				S_BDIV_GO: begin
					if (omb1 == 25'd0) begin
						rate_q <= '1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BDIV;
					end
				end
				S_BDIV: begin
					if (div_rsp.done) begin
						rate_q <= (|div_rsp.quotient[55:32]) ? '1 : div_rsp.quotient[31:0];
						state_q <= S_IDLE;
					end
				end
				S_GDIV: begin
					if (div_rsp.done)
						state_q <= S_UMUL1;
				end
				S_UMUL1: state_q <= S_UMUL2;
				S_UMUL2: state_q <= S_UMUL3;
				S_UMUL3: state_q <= S_UMUL4;
				S_UMUL4: state_q <= S_USQ_GO;
				S_USQ_GO: state_q <= S_USQ;
				S_USQ: begin
					if (sq_rsp.done)
						state_q <= S_UDIV_GO;
				end
				S_UDIV_GO: state_q <= (den_q == 29'd0) ? S_UMULR : S_UDIV;
				S_UDIV: begin
					if (div_rsp.done)
						state_q <= S_UMULR;
				end
				S_UMULR: state_q <= S_UOUT;
				S_UOUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			m_mem[mem_addr] <= clr_q ? 32'd0 : m_new_q;
			v_mem[mem_addr] <= clr_q ? 32'd0 : v_new_q;
		end
		if (pop) begin
			rd_m_q <= m_mem[rd_addr];
			rd_v_q <= v_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head.beat;
		unique case (state_q)
			S_BMUL: rprod_q <= cfg.step * sq_rsp.root;
			S_GDIV: gmag_q <= div_rsp.quotient[31:0];
			S_UMUL1: begin
				p1_q <= $signed({1'b0, cfg.b1}) * m_in;
				p2_q <= $signed({1'b0, omb1c}) * g_s;
				p3_q <= gmag_q * gmag_q;
				p4_q <= cfg.b2 * v_in;
			end
			S_UMUL2: begin
				m_new_q <= mclamp.val;
				sat_q <= mclamp.sat;
				g2_q <= p3_q[63:24];
				v4_q <= p4_q[55:24];
			end
			S_UMUL3: begin
				plo_q <= omb2c * g2_q[19:0];
				phi_q <= omb2c * g2_q[39:20];
			end
			S_UMUL4: begin
				// Clamp the second moment to the positive signed limit.
				if (vsum > 43'h0007fffffff) begin
					v_new_q <= 32'h7fffffff;
					sat_q <= 1'b1;
				end else begin
					v_new_q <= vsum[31:0];
				end
			end
			S_USQ: den_q <= {1'b0, sq_rsp.root} + {5'b0, cfg.eps};
			S_UDIV_GO: begin
				// Zero denominator: pin q to the limit of the moment's sign, or to zero for a zero moment.
				if (den_q == 29'd0) begin
					if (m_new_q == 32'sd0) begin
						q_q <= 32'sd0;
					end else begin
						q_q <= m_new_q[31] ? 32'sh80000000 : 32'sh7fffffff;
						sat_q <= 1'b1;
					end
				end
			end
			S_UDIV: begin
				if (div_rsp.done) begin
					q_q <= qclamp.val;
					sat_q <= sat_q | qclamp.sat;
				end
			end
			S_UMULR: rp_q <= $signed({1'b0, rate_q}) * q_q;
			S_UOUT: begin
				out_index_q <= cur_q.index;
				new_weight_q <= wclamp.val;
				saturated_q <= sat_q | wclamp.sat;
			end
			default: begin
				rp_q <= rp_q;
			end
		endcase
	end

	assign done = done_q;
	assign out_index = out_index_q;
	assign new_weight = new_weight_q;
	assign saturated = saturated_q;

	`ADP_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")
	`ADP_ASSERT_NOW(a_no_pop_clear, pop, !clr_q, "item taken during clearing pass")
	`ADP_ASSERT_NOW(a_upd_we_held, upd_we, cur_q.held && !clr_q,
		"moment write for unheld index or during clear")

endmodule

[hw/rtl/adam_parameter_update.sv]
// Top level of the Adam parameter update block: configuration registers and wiring.
// Depends on adp_pkg, adp_front, adp_back, adp_div and adp_sqrt.
//
// Command channel: drive start with mode, batch_count, param_index, grad_sum and
// old_weight; the beat is taken on a rising edge where start is high and busy is low.
// A two-entry queue sits behind the command port; an idle back end takes the head
// of the queue at the edge after the beat is queued. One item at a time runs there.
// mode 0 begins a step: it stores the batch size, advances both beta powers and
// computes the bias-corrected rate. It returns nothing and holds the back end through
// a 28-step root and a 52-step rate divide, skipped when the divisor is zero.
// mode 1 updates one parameter: the back end runs a 32-step gradient divide, a
// 28-step root and, unless the update denominator is zero, a 56-step quotient
// divide on the shared bit-serial units, then raises done; it can take a queued
// next beat at the edge after done rises, as done is registered from S_UOUT.
// Results: out_index, new_weight and saturated with done high for one cycle; the
// receiver cannot stall. Configuration: cfg_we writes cfg_data to the register at
// cfg_index (step size, beta one, beta two, epsilon) on any edge, with no wait.
// Reset: beta powers and batch size return to one and the rate to zero, then a
// clearing pass zeroes every address of both moment stores with busy high.
module adam_parameter_update #(
	parameter int PARAM_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [12:0]        batch_count,
	input  logic [11:0]        param_index,
	input  logic signed [31:0] grad_sum,
	input  logic signed [31:0] old_weight,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output logic               done,
	output logic [11:0]        out_index,
	output logic signed [31:0] new_weight,
	output logic               saturated
);

	adp_pkg::adp_cfg_t      cfg_q;
	adp_pkg::adp_head_t     head;
	adp_pkg::adp_stat_t     stat;
	adp_pkg::adp_div_req_t  div_req;
	adp_pkg::adp_div_rsp_t  div_rsp;
	adp_pkg::adp_sqrt_req_t sq_req;
	adp_pkg::adp_sqrt_rsp_t sq_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step <= 24'd16777;
			cfg_q.b1 <= 24'd15099494;
			cfg_q.b2 <= 24'd16760438;
			cfg_q.eps <= 24'd1;
		end else if (cfg_we) begin
			unique case (adp_pkg::adp_reg_t'(cfg_index))
				adp_pkg::REG_STEP: cfg_q.step <= cfg_data;
				adp_pkg::REG_B1:   cfg_q.b1 <= cfg_data;
				adp_pkg::REG_B2:   cfg_q.b2 <= cfg_data;
				adp_pkg::REG_EPS:  cfg_q.eps <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	adp_front #(
		.PARAM_DEPTH(PARAM_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.batch_count (batch_count),
		.param_index (param_index),
		.grad_sum    (grad_sum),
		.old_weight  (old_weight),
		.stat        (stat),
		.head        (head)
	);

	adp_back #(
		.PARAM_DEPTH(PARAM_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.stat       (stat),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.sq_req     (sq_req),
		.sq_rsp     (sq_rsp),
		.done       (done),
		.out_index  (out_index),
		.new_weight (new_weight),
		.saturated  (saturated)
	);

	adp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	adp_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

endmodule

[bench/adam_parameter_update_tb.sv]
// Testbench of the Adam parameter update block: directed and random command beats.
// A scoreboard class predicts each result in fixed point; depends on adp_pkg and the RTL.
module adam_parameter_update_tb;

	localparam longint QONE = 64'sd16777216;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;

	typedef struct {
		logic [11:0]        index;
		logic signed [31:0] weight;
		logic               sat;
	} upd_res_t;

	class adam_scoreboard;
		logic [23:0] step, b1, b2, eps;
		int          first_mom [4096];
		int          second_mom[4096];
		longint      b1_pow, b2_pow, batch;
		longint      rate;
		bit          sat_hit;
		int          errors;
		upd_res_t    pending[$];

		function new();
			step = 24'd16777;
			b1 = 24'd15099494;
			b2 = 24'd16760438;
			eps = 24'd1;
			foreach (first_mom[i]) begin
				first_mom[i] = 0;
				second_mom[i] = 0;
			end
			b1_pow = QONE;
			b2_pow = QONE;
			batch = 1;
			rate = 0;
			errors = 0;
		endfunction

		function void write_reg(adp_pkg::adp_reg_t idx, logic [23:0] val);
			case (idx)
				adp_pkg::REG_STEP: step = val;
				adp_pkg::REG_B1:   b1 = val;
				adp_pkg::REG_B2:   b2 = val;
				adp_pkg::REG_EPS:  eps = val;
			endcase
		endfunction

		function longint qmul(longint a, longint b);
			return (a * b) / QONE;
		endfunction

		function longint unsigned isqrt(longint unsigned x);
			longint unsigned r = 0;
			longint unsigned bt = 64'h4000000000000000;
			while (bt > x)
				bt >>= 2;
			while (bt != 0) begin
				if (x >= r + bt) begin
					x -= r + bt;
					r = (r >> 1) + bt;
				end else begin
					r >>= 1;
				end
				bt >>= 2;
			end
			return r;
		endfunction

		function longint clamp(longint x);
			if (x > SMAX) begin
				sat_hit = 1;
				return SMAX;
			end
			if (x < SMIN) begin
				sat_hit = 1;
				return SMIN;
			end
			return x;
		endfunction

		// note an accepted command beat
		function void note(logic md, logic [12:0] bs, logic [11:0] idx,
				logic signed [31:0] grad, logic signed [31:0] w);
			longint   beta1, beta2, s, den, g, m, v, g2, q, nw;
			upd_res_t r;
			beta1 = (longint'(b1) > QONE) ? QONE : longint'(b1);
			beta2 = (longint'(b2) > QONE) ? QONE : longint'(b2);
			sat_hit = 0;
			if (!md) begin
				batch = (bs == 0) ? 1 : longint'(bs);
				b1_pow = qmul(b1_pow, beta1);
				b2_pow = qmul(b2_pow, beta2);
				s = isqrt((QONE - b2_pow) << 24);
				den = QONE - b1_pow;
				if (den == 0) begin
					rate = 64'hFFFFFFFF;
				end else begin
					rate = (longint'(step) * s) / den;
					if (rate > 64'hFFFFFFFF)
						rate = 64'hFFFFFFFF;
				end
				return;
			end
			g = longint'(grad) / batch;
			m = clamp(qmul(beta1, first_mom[idx]) + qmul(QONE - beta1, g));
			g2 = (g * g) / QONE;
			v = qmul(beta2, second_mom[idx]) + qmul(QONE - beta2, g2);
			if (v > SMAX) begin
				v = SMAX;
				sat_hit = 1;
			end
			first_mom[idx] = int'(m);
			second_mom[idx] = int'(v);
			den = longint'(isqrt(v << 24)) + longint'(eps);
			if (den == 0) begin
				if (m == 0) begin
					q = 0;
				end else begin
					q = (m > 0) ? SMAX : SMIN;
					sat_hit = 1;
				end
			end else begin
				q = clamp((m * QONE) / den);
			end
			nw = clamp(longint'(w) - (rate * q) / QONE);
			r.index = idx;
			r.weight = nw[31:0];
			r.sat = sat_hit;
			pending.push_back(r);
		endfunction

		function void check(logic [11:0] idx, logic signed [31:0] w, logic sat);
			upd_res_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat, out_index %0d", idx);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (idx !== e.index) begin
				$error("out_index expected %0d actual %0d", e.index, idx);
				errors++;
			end
			if (w !== e.weight) begin
				$error("new_weight expected %0d actual %0d", e.weight, w);
				errors++;
			end
			if (sat !== e.sat) begin
				$error("saturated expected %0d actual %0d", e.sat, sat);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic               mode = 0;
	logic [12:0]        batch_count = 0;
	logic [11:0]        param_index = 0;
	logic signed [31:0] grad_sum = 0;
	logic signed [31:0] old_weight = 0;
	logic               cfg_we = 0;
	logic [1:0]         cfg_index = 0;
	logic [23:0]        cfg_data = 0;
	logic               done;
	logic [11:0]        out_index;
	logic signed [31:0] new_weight;
	logic               saturated;

	adam_scoreboard sb = new();
	int gap_pct = 0;

	adam_parameter_update u_top (.*);

	always #5 clk = ~clk;

	always @(posedge clk)
		if (arst_n && done)
			sb.check(out_index, new_weight, saturated);

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send(logic md, logic [12:0] bs, logic [11:0] idx,
			logic signed [31:0] g, logic signed [31:0] w);
		while ($urandom_range(0, 99) < gap_pct) begin
			start = 0;
			@(negedge clk);
		end
		start = 1;
		mode = md;
		batch_count = bs;
		param_index = idx;
		grad_sum = g;
		old_weight = w;
		do
			@(posedge clk);
		while (busy);
		sb.note(md, bs, idx, g, w);
		@(negedge clk);
	endtask

	// drain the block; a begin step may still be running after the last result
	task automatic settle();
		start = 0;
		while (sb.pending.size() != 0 || busy)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic set_reg(adp_pkg::adp_reg_t idx, logic [23:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		sb.write_reg(idx, val);
	endtask

	task automatic set_all(logic [23:0] st, logic [23:0] d1, logic [23:0] d2,
			logic [23:0] e);
		set_reg(adp_pkg::REG_STEP, st);
		set_reg(adp_pkg::REG_B1, d1);
		set_reg(adp_pkg::REG_B2, d2);
		set_reg(adp_pkg::REG_EPS, e);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return $signed($urandom_range(0, 4095)) - 2048;
			4: return $signed($urandom_range(0, 33554432)) - 16777216;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_beat();
		logic [12:0] bs;
		logic [11:0] idx;
		if ($urandom_range(0, 15) == 0) begin
			case ($urandom_range(0, 3))
				0: bs = 0;
				1: bs = 1;
				2: bs = 13'($urandom_range(1, 4096));
				default: bs = 13'($urandom);
			endcase
			send(0, bs, 12'($urandom), 32'($urandom), 32'($urandom));
		end else begin
			// reuse a few indexes so the moments build up
			idx = ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'($urandom_range(0, 7));
			send(1, 13'($urandom), idx, pick_value(), pick_value());
		end
	endtask

	task automatic phase(int pct, int count);
		gap_pct = pct;
		repeat (count) random_beat();
		settle();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1;
		// rate is still zero, weight must pass through
		send(1, 0, 0, 0, 0);
		send(1, 0, 4095, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send(0, 0, 0, 0, 0);
		send(1, 0, 1, 32'sh80000000, 32'sh80000000);
		send(1, 0, 1, 32'sh7FFFFFFF, 0);
		send(0, 4096, 0, 0, 0);
		send(1, 0, 2, 32'sh80000000, 32'sh7FFFFFFF);
		send(0, 8191, 0, 0, 0);
		send(1, 0, 3, 1, 32'sh7FFFFFFF);
		settle();
		// zero epsilon and zero betas: zero update denominator cases
		set_all(24'hFFFFFF, 24'd0, 24'd0, 24'd0);
		send(1, 0, 10, 0, 12345);
		send(0, 1, 0, 0, 0);
		send(1, 0, 11, 1, 0);
		send(1, 0, 12, -1, 0);
		send(1, 0, 13, 32'sh80000000, 32'sh7FFFFFFF);
		send(1, 0, 14, 32'sh7FFFFFFF, 32'sh80000000);
		send(1, 0, 15, 32'sh00001000, 32'sh80000000);
		settle();
		set_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send(0, 2, 0, 0, 0);
		send(1, 0, 16, 32'sh7FFFFFFF, 0);
		send(1, 0, 16, 32'sh80000000, 0);
		send(0, 1, 0, 0, 0);
		send(1, 0, 17, 32'sh01000000, 32'sh7FFFFFFF);
		settle();
		set_all(24'd16777, 24'd15099494, 24'd16760438, 24'd1);
		phase(10, 350);
		set_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom_range(0, 255)));
		phase(70, 350);
		set_all(24'hFFFFFF, 24'd8388608, 24'd16000000, 24'd0);
		phase(0, 350);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("adam_parameter_update_tb: clean");
		end else begin
			if (sb.pending.size() != 0)
				$error("%0d expected results never arrived", sb.pending.size());
			$display("adam_parameter_update_tb: errors");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("adam_parameter_update_tb: errors");
		$finish;
	end

endmodule
